// ===== rtl/pcb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcb_pkg
// Shared field widths, request/result structs and codes for the particle
// cell binning block.
// ---------------------------------------------------------------------------
package pcb_pkg;

  localparam int PID_W      = 12;
  localparam int POS_W      = 24;
  localparam int SCALE_W    = 24;
  localparam int SIDE_W     = 7;
  localparam int OLD_W      = 13;
  localparam int CELL_W     = 12;
  localparam int CNT_W      = 5;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 1;
  // fraction bits of the Q8.16 x Q8.16 product
  localparam int PROD_FRAC  = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd6553600;
  localparam logic [SIDE_W-1:0]  SIDE_RESET  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_SAME  = 2'd0,
    STAT_MOVED = 2'd1,
    STAT_FIRST = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [PID_W-1:0] particle_id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [OLD_W-1:0] old_cell;
    logic [CELL_W-1:0] new_cell;
    logic [CNT_W-1:0] new_count;
  } res_t;

  // cell unit phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_Y,
    PH_SUM
  } cu_phase_t;

  // main sequencer
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_OLD,
    S_CNT,
    S_RMCNT,
    S_RMLAST,
    S_RMSRCH,
    S_ADDCNT,
    S_PIDRD,
    S_PIDWR,
    S_FIN
  } state_t;

endpackage

// ===== rtl/pcb_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module pcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pcb_cell_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcb_cell_unit
// Position to cell index: one shared 24x24 multiplier for x then y,
// saturation to the grid side, then x cell * side + y cell.
// ---------------------------------------------------------------------------
module pcb_cell_unit #(
  parameter int MAX_SIDE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [pcb_pkg::POS_W-1:0]            pos_x,
  input  logic [pcb_pkg::POS_W-1:0]            pos_y,
  input  logic [pcb_pkg::SCALE_W-1:0]          scale,
  input  logic [$clog2(MAX_SIDE+1)-1:0]        side,
  output logic                                 done,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] cell_idx
);
  import pcb_pkg::*;

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = $clog2(MAX_SIDE);
  localparam int CW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int PW = POS_W + SCALE_W;
  localparam int IW = PW - PROD_FRAC;

  cu_phase_t       ph, ph_next;
  logic [POS_W-1:0] mul_a;
  logic [PW-1:0]    prod;
  logic [AW-1:0]    cx;
  logic [AW-1:0]    c_sat;

  function automatic logic [AW-1:0] sat_axis(input logic [IW-1:0] c,
                                             input logic [SW-1:0] s);
    logic [SW-1:0] s_last;
    s_last = s - 1'b1;
    return (32'(c) >= 32'(s)) ? AW'(s_last) : AW'(c);
  endfunction

  // phase sequencing
  always_comb begin
    ph_next = ph;
    unique case (ph)
      PH_IDLE: if (start) ph_next = PH_X;
      PH_X:    ph_next = PH_Y;
      PH_Y:    ph_next = PH_SUM;
      PH_SUM:  ph_next = PH_IDLE;
      default: ph_next = PH_IDLE;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (ph)
      PH_Y:    mul_a = pos_y;
      default: mul_a = pos_x;
    endcase
  end

  assign c_sat = sat_axis(prod[PW-1:PROD_FRAC], side);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      ph   <= ph_next;
      done <= (ph == PH_SUM);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * scale;
    if (ph == PH_Y) begin
      cx <= c_sat;
    end
    if (ph == PH_SUM) begin
      cell_idx <= CW'(cx) * CW'(side) + CW'(c_sat);
    end
  end

endmodule

// ===== rtl/particle_cell_binning.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_cell_binning
// Places particles into square grid cells and keeps per-cell member bins.
// ---------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall / req): particle id and Q8.16
//   x,y position; a request is taken when req_valid is high and req_stall
//   is low. result channel (res_valid / res_stall / res): status, previous
//   cell, new cell and new bin occupancy, one result per request.
//   cfg_we / cfg_index / cfg_data write scale (index 0) or grid side
//   (index 1); write only while no request is in flight.
//   steps from accept to res_valid: cell unit, old record read, then count
//   read for a same-cell or out-of-range request; else new bin add, pid read
//   and pid write, after an old count read on a move and, unless the old bin
//   is empty, a last member read and a search of the old bin slots, one member
//   RAM read per cycle (at most BIN_DEPTH). the next request is taken in the
//   idle state after the result loads. one request in flight.
//   reset: a clearing pass over the max(MAX_PARTICLES, MAX_SIDE*MAX_SIDE)
//   (4096 by default) table RAM entries writes "no cell" and zero counts;
//   req_stall stays high until it is done. config writes go through.
//   a stalled result holds in the output register; the next request is
//   taken meanwhile and waits at its end until the register frees.
// ---------------------------------------------------------------------------
module particle_cell_binning #(
  parameter int MAX_PARTICLES = 4096,
  parameter int MAX_SIDE      = 64,
  parameter int BIN_DEPTH     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  pcb_pkg::req_t                   req,
  output logic                            res_valid,
  input  logic                            res_stall,
  output pcb_pkg::res_t                   res,
  input  logic                            cfg_we,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcb_pkg::CFG_W-1:0]       cfg_data
);
  import pcb_pkg::*;

  localparam int NCELL  = MAX_SIDE * MAX_SIDE;
  localparam int CW     = $clog2(NCELL);
  localparam int PCW    = $clog2(NCELL + 1);
  localparam int CNTW   = $clog2(BIN_DEPTH + 1);
  localparam int TDEPTH = (MAX_PARTICLES > NCELL) ? MAX_PARTICLES : NCELL;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int TW     = PCW + CNTW;
  localparam int MDEPTH = NCELL * BIN_DEPTH;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int SW     = $clog2(MAX_SIDE + 1);

  localparam logic [PCW-1:0]  NO_CELL  = PCW'(NCELL);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(BIN_DEPTH);

  // configuration
  logic [SCALE_W-1:0] scale;
  logic [SIDE_W-1:0]  grid_side;
  logic [SW-1:0]      side_eff;

  // sequencer
  state_t state, state_next;
  logic [TAW-1:0] clr_q;

  // request context
  req_t            req_q;
  logic            pid_ok;
  logic [CW-1:0]   cell_q;
  logic [PCW-1:0]  rec_q;       // record before the update
  logic [PCW-1:0]  ocell_rec;   // record field sharing the old bin's entry
  logic [PCW-1:0]  new_rec;
  logic [MAW-1:0]  new_base;
  logic [MAW-1:0]  old_base;
  logic [CNTW-1:0] n_q;
  logic [CNTW-1:0] k_q;
  logic [CNTW-1:0] cnt_q;
  logic [PID_W-1:0] last_q;
  status_t         status_q;

  // cell unit
  logic          cu_start;
  logic          cu_done;
  logic [CW-1:0] cu_cell;

  // table RAM: {particle record, bin count}, one entry per particle and cell
  logic           tab_we;
  logic [TAW-1:0] tab_waddr;
  logic [TW-1:0]  tab_wdata;
  logic [TAW-1:0] tab_raddr;
  logic [TW-1:0]  tab_rdata;
  logic [PCW-1:0] rd_rec;
  logic [CNTW-1:0] rd_cnt;

  // member RAM: BIN_DEPTH slots per cell
  logic             mem_we;
  logic [MAW-1:0]   mem_waddr;
  logic [PID_W-1:0] mem_wdata;
  logic [MAW-1:0]   mem_raddr;
  logic [PID_W-1:0] mem_rdata;

  // decode helpers
  logic [TAW-1:0]  pid_addr;
  logic [TAW-1:0]  cell_addr;
  logic            same_cell;
  logic            rd_old_valid;
  logic            rec_valid;
  logic [CNTW-1:0] n_clamp;
  logic            hit;
  logic            last_k;
  logic            bin_full;
  logic            res_load;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RESET;
      grid_side <= SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: scale     <= cfg_data[SCALE_W-1:0];
        REG_SIDE:  grid_side <= cfg_data[SIDE_W-1:0];
        default:   ;
      endcase
    end
  end

  // side of zero acts as one, side above the grid saturates
  always_comb begin
    if (grid_side == '0) begin
      side_eff = SW'(1);
    end else if (32'(grid_side) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(grid_side);
    end
  end

  // ---- cell index unit ----
  pcb_cell_unit #(
    .MAX_SIDE(MAX_SIDE)
  ) u_cell (
    .clk      (clk),
    .rst      (rst),
    .start    (cu_start),
    .pos_x    (req_q.pos_x),
    .pos_y    (req_q.pos_y),
    .scale    (scale),
    .side     (side_eff),
    .done     (cu_done),
    .cell_idx (cu_cell)
  );

  // ---- memories ----
  pcb_ram #(
    .WIDTH(TW),
    .DEPTH(TDEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  pcb_ram #(
    .WIDTH(PID_W),
    .DEPTH(MDEPTH)
  ) u_members (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---- decode helpers ----
  assign rd_rec       = tab_rdata[TW-1:CNTW];
  assign rd_cnt       = tab_rdata[CNTW-1:0];
  assign pid_addr     = TAW'(req_q.particle_id);
  assign cell_addr    = TAW'(cell_q);
  assign same_cell    = (rd_rec == PCW'(cell_q));
  assign rd_old_valid = (32'(rd_rec) < NCELL);
  assign rec_valid    = (32'(rec_q) < NCELL);
  assign n_clamp      = (32'(rd_cnt) > BIN_DEPTH) ? FULL_CNT : rd_cnt;
  assign hit          = (mem_rdata == req_q.particle_id);
  assign last_k       = (k_q == n_q - 1'b1);
  assign bin_full     = (32'(rd_cnt) >= BIN_DEPTH);
  assign res_load     = (state == S_FIN) && (!res_valid || !res_stall);

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_q == TAW'(TDEPTH - 1)) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = S_CALC;
      S_CALC:   if (cu_done) state_next = S_OLD;
      S_OLD: begin
        if (!pid_ok || same_cell) begin
          state_next = S_CNT;
        end else if (rd_old_valid) begin
          state_next = S_RMCNT;
        end else begin
          state_next = S_ADDCNT;
        end
      end
      S_CNT:    state_next = S_FIN;
      S_RMCNT:  state_next = (n_clamp == '0) ? S_ADDCNT : S_RMLAST;
      S_RMLAST: state_next = S_RMSRCH;
      S_RMSRCH: if (hit || last_k) state_next = S_ADDCNT;
      S_ADDCNT: state_next = S_PIDRD;
      S_PIDRD:  state_next = S_PIDWR;
      S_PIDWR:  state_next = S_FIN;
      S_FIN:    if (!res_valid || !res_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---- memory and handshake controls ----
  always_comb begin
    req_stall = (state != S_IDLE);
    cu_start  = (state == S_IDLE) && req_valid;
    tab_we    = 1'b0;
    tab_waddr = pid_addr;
    tab_wdata = {new_rec, rd_cnt};
    tab_raddr = pid_addr;
    mem_we    = 1'b0;
    mem_waddr = old_base + MAW'(k_q);
    mem_wdata = last_q;
    mem_raddr = old_base;
    unique case (state)
      S_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_q;
        tab_wdata = {NO_CELL, CNTW'(0)};
      end
      S_OLD: begin
        // old bin count next if there is a removal, else the new bin
        if (!pid_ok || same_cell || !rd_old_valid) begin
          tab_raddr = cell_addr;
        end else begin
          tab_raddr = TAW'(rd_rec);
        end
      end
      S_RMCNT: begin
        if (n_clamp == '0) begin
          tab_raddr = cell_addr;
        end else begin
          mem_raddr = old_base + MAW'(n_clamp - 1'b1);
        end
      end
      S_RMLAST: mem_raddr = old_base;
      S_RMSRCH: begin
        // next slot read ahead while comparing the current one
        mem_raddr = old_base + MAW'(k_q + 1'b1);
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = old_base + MAW'(k_q);
          mem_wdata = last_q;
          tab_we    = 1'b1;
          tab_waddr = TAW'(rec_q);
          tab_wdata = {ocell_rec, n_q - 1'b1};
        end
        if (hit || last_k) begin
          tab_raddr = cell_addr;
        end
      end
      S_ADDCNT: begin
        if (!bin_full) begin
          mem_we    = 1'b1;
          mem_waddr = new_base + MAW'(rd_cnt);
          mem_wdata = req_q.particle_id;
          tab_we    = 1'b1;
          tab_waddr = cell_addr;
          tab_wdata = {rd_rec, rd_cnt + 1'b1};
        end
      end
      S_PIDWR: begin
        // record update keeps the bin count sharing this entry
        tab_we    = 1'b1;
        tab_waddr = pid_addr;
        tab_wdata = {new_rec, rd_cnt};
      end
      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_q     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // ---- request context and result ----
  always_ff @(posedge clk) begin
    if (cu_start) begin
      req_q  <= req;
      pid_ok <= (32'(req.particle_id) < MAX_PARTICLES);
    end
    unique case (state)
      S_CALC: if (cu_done) cell_q <= cu_cell;
      S_OLD: begin
        new_base <= MAW'(cell_q) * MAW'(BIN_DEPTH);
        old_base <= MAW'(rd_rec) * MAW'(BIN_DEPTH);
        rec_q    <= pid_ok ? rd_rec : NO_CELL;
        if (!pid_ok) begin
          status_q <= STAT_FULL;
        end else if (same_cell) begin
          status_q <= STAT_SAME;
        end
      end
      S_CNT: cnt_q <= rd_cnt;
      S_RMCNT: begin
        ocell_rec <= rd_rec;
        n_q       <= n_clamp;
      end
      S_RMLAST: begin
        last_q <= mem_rdata;
        k_q    <= '0;
      end
      S_RMSRCH: k_q <= k_q + 1'b1;
      S_ADDCNT: begin
        if (bin_full) begin
          status_q <= STAT_FULL;
          cnt_q    <= rd_cnt;
          new_rec  <= NO_CELL;
        end else begin
          status_q <= rec_valid ? STAT_MOVED : STAT_FIRST;
          cnt_q    <= rd_cnt + 1'b1;
          new_rec  <= PCW'(cell_q);
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res.status    <= status_q;
      res.old_cell  <= OLD_W'(rec_q);
      res.new_cell  <= CELL_W'(cell_q);
      res.new_count <= CNT_W'(cnt_q);
    end
  end

`ifndef SYNTHESIS
  // cell unit finishes only while the sequencer waits for it
  a_cu_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    cu_done |-> (state == S_CALC))
    else $error("cell unit done outside calc");

  // search index stays inside the old bin
  a_search_in_bin: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMSRCH) |-> (k_q < n_q))
    else $error("bin search index past bin count");

  // a new result comes only from the finish step
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside finish");
`endif

endmodule
